@@ design/ple_pkg.sv @@
package ple_pkg;

    // list geometry
    localparam int CAPACITY = 64;
    localparam int ADDR_W   = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int DATA_W   = 32;
    localparam int CNT_W    = 7;
    localparam int FIDX_W   = 6;
    localparam int CMD_W    = 4;
    localparam int ST_W     = 3;

    // command codes
    typedef enum logic [CMD_W-1:0] {
        CMD_ADD_FRONT    = 4'd0,
        CMD_ADD_BACK     = 4'd1,
        CMD_INSERT_AT    = 4'd2,
        CMD_REMOVE_FRONT = 4'd3,
        CMD_REMOVE_BACK  = 4'd4,
        CMD_REMOVE_AT    = 4'd5,
        CMD_SEARCH       = 4'd6,
        CMD_UPDATE       = 4'd7,
        CMD_REVERSE      = 4'd8,
        CMD_DUMP         = 4'd9
    } cmd_t;

    // result status codes
    typedef enum logic [ST_W-1:0] {
        ST_OK        = 3'd0,
        ST_EMPTY     = 3'd1,
        ST_INVALID   = 3'd2,
        ST_FULL      = 3'd3,
        ST_NOT_FOUND = 3'd4
    } status_t;

endpackage

@@ design/positional_list_engine_core.sv @@
// Ordered list of up to CAPACITY signed 32-bit entries kept in one single-port-write
// RAM. A command is taken when start is high and busy is low; a command that needs
// more steps keeps busy high until it has finished. Every command answers with one
// result beat (done high for one cycle, last high), except a dump of a non-empty
// list, which gives one beat per entry on consecutive cycles, front first, last high
// on the final one. The receiver cannot stall: each beat must be taken in the cycle
// it appears. The RAM moves or reads one entry per cycle. Rejected commands, an add
// or insert at the end, update, remove of the final entry and reverse of fewer than
// two entries answer in the cycle after start; insert at an index below the end
// first shifts the later entries up and then writes the new one, remove of any other
// entry shifts the later entries down, search stops at the first hit, dump gives one
// beat per cycle once its first read returns, and reverse swaps one pair at a time.
// No clearing is done after reset: the list starts empty.
module positional_list_engine_core
    import ple_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     start,
    output logic                     busy,
    input  logic [CMD_W-1:0]         cmd,
    input  logic signed [DATA_W-1:0] entry_value,
    input  logic [CNT_W-1:0]         index,
    output logic                     done,
    output logic [ST_W-1:0]          status,
    output logic                     found,
    output logic [FIDX_W-1:0]        found_index,
    output logic signed [DATA_W-1:0] out_value,
    output logic [CNT_W-1:0]         entry_count,
    output logic                     last
);

    typedef enum logic [9:0] {
        S_IDLE       = 10'b0000000001,
        S_SHIFT_UP   = 10'b0000000010,
        S_PUT        = 10'b0000000100,
        S_SHIFT_DOWN = 10'b0000001000,
        S_SEARCH     = 10'b0000010000,
        S_DUMP       = 10'b0000100000,
        S_REV_A      = 10'b0001000000,
        S_REV_B      = 10'b0010000000,
        S_REV_C      = 10'b0100000000,
        S_REV_D      = 10'b1000000000
    } state_t;

    state_t                   state_reg, state_next;
    logic [CNT_W-1:0]         count_reg, count_next;
    logic [ADDR_W-1:0]        ptr_reg, ptr_next;
    logic [ADDR_W-1:0]        stop_reg, stop_next;
    logic                     issue_reg, issue_next;
    logic                     lag_valid_reg, lag_valid_next;
    logic [ADDR_W-1:0]        lag_addr_reg, lag_addr_next;
    logic signed [DATA_W-1:0] value_reg, value_next;
    logic [DATA_W-1:0]        hold_reg, hold_next;

    logic                     done_reg, done_next;
    status_t                  status_reg, status_next;
    logic                     found_reg, found_next;
    logic [FIDX_W-1:0]        found_index_reg, found_index_next;
    logic [DATA_W-1:0]        out_value_reg, out_value_next;
    logic [CNT_W-1:0]         entry_count_reg, entry_count_next;
    logic                     last_reg, last_next;

    logic                     ram_we;
    logic [ADDR_W-1:0]        ram_waddr;
    logic [DATA_W-1:0]        ram_wdata;
    logic [ADDR_W-1:0]        ram_raddr;
    logic [DATA_W-1:0]        ram_rdata;

    logic [CNT_W-1:0]         ins_pos;
    logic [CNT_W-1:0]         del_pos;
    logic [CNT_W-1:0]         count_dec;
    logic                     list_full;
    logic                     list_empty;
    logic                     scan_active;
    logic [ADDR_W-1:0]        rev_gap;

    ple_ram #(
        .WIDTH (DATA_W),
        .DEPTH (CAPACITY)
    ) u_store (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // positions of the add and remove flavors
    assign count_dec  = count_reg - 7'd1;
    assign list_full  = (count_reg == CNT_W'(CAPACITY));
    assign list_empty = (count_reg == '0);
    assign rev_gap    = stop_reg - ptr_reg;

    always_comb
    begin
        case (cmd_t'(cmd))
            CMD_ADD_FRONT: ins_pos = '0;
            CMD_ADD_BACK:  ins_pos = count_reg;
            default:       ins_pos = index;
        endcase
        case (cmd_t'(cmd))
            CMD_REMOVE_FRONT: del_pos = '0;
            CMD_REMOVE_BACK:  del_pos = list_empty ? '0 : count_dec;
            default:          del_pos = index;
        endcase
    end

    assign scan_active = (state_reg inside {S_SHIFT_UP, S_SHIFT_DOWN, S_SEARCH, S_DUMP});

    // sequencer
    always_comb
    begin
        state_next       = state_reg;
        count_next       = count_reg;
        ptr_next         = ptr_reg;
        stop_next        = stop_reg;
        issue_next       = issue_reg;
        lag_valid_next   = 1'b0;
        lag_addr_next    = ptr_reg;
        value_next       = value_reg;
        hold_next        = hold_reg;

        done_next        = 1'b0;
        status_next      = ST_OK;
        found_next       = 1'b0;
        found_index_next = '0;
        out_value_next   = '0;
        last_next        = 1'b1;

        ram_we           = 1'b0;
        ram_waddr        = ptr_reg;
        ram_wdata        = value_reg;
        ram_raddr        = ptr_reg;

        // shared scan step: one read per cycle, the registered read data comes back in the next cycle
        if (scan_active)
        begin
            lag_valid_next = issue_reg;
            lag_addr_next  = ptr_reg;
            if (issue_reg)
            begin
                if (ptr_reg == stop_reg)
                begin
                    issue_next = 1'b0;
                end
                else if (state_reg == S_SHIFT_UP)
                begin
                    ptr_next = ptr_reg - 1'b1;
                end
                else
                begin
                    ptr_next = ptr_reg + 1'b1;
                end
            end
        end

        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    value_next = entry_value;
                    case (cmd_t'(cmd))
                        CMD_ADD_FRONT, CMD_ADD_BACK, CMD_INSERT_AT:
                        begin
                            if (list_full)
                            begin
                                done_next   = 1'b1;
                                status_next = ST_FULL;
                            end
                            else if (ins_pos > count_reg)
                            begin
                                done_next   = 1'b1;
                                status_next = ST_INVALID;
                            end
                            else if (ins_pos == count_reg)
                            begin
                                ram_we     = 1'b1;
                                ram_waddr  = ADDR_W'(ins_pos);
                                ram_wdata  = entry_value;
                                count_next = count_reg + 7'd1;
                                done_next  = 1'b1;
                            end
                            else
                            begin
                                ptr_next   = ADDR_W'(count_dec);
                                stop_next  = ADDR_W'(ins_pos);
                                issue_next = 1'b1;
                                state_next = S_SHIFT_UP;
                            end
                        end
                        CMD_REMOVE_FRONT, CMD_REMOVE_BACK, CMD_REMOVE_AT:
                        begin
                            if (list_empty)
                            begin
                                done_next   = 1'b1;
                                status_next = ST_EMPTY;
                            end
                            else if (del_pos >= count_reg)
                            begin
                                done_next   = 1'b1;
                                status_next = ST_INVALID;
                            end
                            else if (del_pos == count_dec)
                            begin
                                count_next = count_dec;
                                done_next  = 1'b1;
                            end
                            else
                            begin
                                ptr_next   = ADDR_W'(del_pos + 7'd1);
                                stop_next  = ADDR_W'(count_dec);
                                issue_next = 1'b1;
                                state_next = S_SHIFT_DOWN;
                            end
                        end
                        CMD_SEARCH:
                        begin
                            if (list_empty)
                            begin
                                done_next   = 1'b1;
                                status_next = ST_NOT_FOUND;
                            end
                            else
                            begin
                                ptr_next   = '0;
                                stop_next  = ADDR_W'(count_dec);
                                issue_next = 1'b1;
                                state_next = S_SEARCH;
                            end
                        end
                        CMD_UPDATE:
                        begin
                            done_next = 1'b1;
                            if (index >= count_reg)
                            begin
                                status_next = ST_INVALID;
                            end
                            else
                            begin
                                ram_we    = 1'b1;
                                ram_waddr = ADDR_W'(index);
                                ram_wdata = entry_value;
                            end
                        end
                        CMD_REVERSE:
                        begin
                            if (count_reg < 7'd2)
                            begin
                                done_next = 1'b1;
                            end
                            else
                            begin
                                ptr_next   = '0;
                                stop_next  = ADDR_W'(count_dec);
                                state_next = S_REV_A;
                            end
                        end
                        CMD_DUMP:
                        begin
                            if (list_empty)
                            begin
                                done_next   = 1'b1;
                                status_next = ST_EMPTY;
                            end
                            else
                            begin
                                ptr_next   = '0;
                                stop_next  = ADDR_W'(count_dec);
                                issue_next = 1'b1;
                                state_next = S_DUMP;
                            end
                        end
                        default:
                        begin
                            done_next = 1'b1;
                        end
                    endcase
                end
            end

            // move entries up by one, back to front
            S_SHIFT_UP:
            begin
                if (lag_valid_reg)
                begin
                    ram_we    = 1'b1;
                    ram_waddr = lag_addr_reg + 1'b1;
                    ram_wdata = ram_rdata;
                end
                if (!issue_reg)
                begin
                    lag_valid_next = 1'b0;
                    state_next     = S_PUT;
                end
            end

            // drop the new entry into the freed slot
            S_PUT:
            begin
                ram_we     = 1'b1;
                ram_waddr  = stop_reg;
                ram_wdata  = value_reg;
                count_next = count_reg + 7'd1;
                done_next  = 1'b1;
                state_next = S_IDLE;
            end

            // move entries down by one, front to back
            S_SHIFT_DOWN:
            begin
                if (lag_valid_reg)
                begin
                    ram_we    = 1'b1;
                    ram_waddr = lag_addr_reg - 1'b1;
                    ram_wdata = ram_rdata;
                end
                if (!issue_reg)
                begin
                    lag_valid_next = 1'b0;
                    count_next     = count_dec;
                    done_next      = 1'b1;
                    state_next     = S_IDLE;
                end
            end

            // compare each returned entry, stop at the first hit
            S_SEARCH:
            begin
                if (lag_valid_reg && (ram_rdata == value_reg))
                begin
                    done_next        = 1'b1;
                    found_next       = 1'b1;
                    found_index_next = FIDX_W'(lag_addr_reg);
                    issue_next       = 1'b0;
                    lag_valid_next   = 1'b0;
                    state_next       = S_IDLE;
                end
                else if (!issue_reg)
                begin
                    done_next      = 1'b1;
                    status_next    = ST_NOT_FOUND;
                    lag_valid_next = 1'b0;
                    state_next     = S_IDLE;
                end
            end

            // one beat per returned entry
            S_DUMP:
            begin
                if (lag_valid_reg)
                begin
                    done_next      = 1'b1;
                    out_value_next = ram_rdata;
                    last_next      = !issue_reg;
                end
                if (!issue_reg)
                begin
                    lag_valid_next = 1'b0;
                    state_next     = S_IDLE;
                end
            end

            // reverse: read low, read high, write low, write high
            S_REV_A:
            begin
                ram_raddr  = ptr_reg;
                state_next = S_REV_B;
            end

            S_REV_B:
            begin
                ram_raddr  = stop_reg;
                hold_next  = ram_rdata;
                state_next = S_REV_C;
            end

            S_REV_C:
            begin
                ram_we     = 1'b1;
                ram_waddr  = ptr_reg;
                ram_wdata  = ram_rdata;
                state_next = S_REV_D;
            end

            S_REV_D:
            begin
                ram_we    = 1'b1;
                ram_waddr = stop_reg;
                ram_wdata = hold_reg;
                if (rev_gap > ADDR_W'(2))
                begin
                    ram_raddr  = ptr_reg + 1'b1;
                    ptr_next   = ptr_reg + 1'b1;
                    stop_next  = stop_reg - 1'b1;
                    state_next = S_REV_B;
                end
                else
                begin
                    done_next  = 1'b1;
                    state_next = S_IDLE;
                end
            end

            default:
            begin
                issue_next = 1'b0;
                state_next = S_IDLE;
            end
        endcase

        entry_count_next = count_next;
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            issue_reg     <= 1'b0;
            lag_valid_reg <= 1'b0;
            done_reg      <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            issue_reg     <= issue_next;
            lag_valid_reg <= lag_valid_next;
            done_reg      <= done_next;
        end
    end

    // datapath and result beat payload
    always_ff @(posedge clk)
    begin
        ptr_reg         <= ptr_next;
        stop_reg        <= stop_next;
        lag_addr_reg    <= lag_addr_next;
        value_reg       <= value_next;
        hold_reg        <= hold_next;
        status_reg      <= status_next;
        found_reg       <= found_next;
        found_index_reg <= found_index_next;
        out_value_reg   <= out_value_next;
        entry_count_reg <= entry_count_next;
        last_reg        <= last_next;
    end

    assign busy        = (state_reg != S_IDLE);
    assign done        = done_reg;
    assign status      = status_reg;
    assign found       = found_reg;
    assign found_index = found_index_reg;
    assign out_value   = out_value_reg;
    assign entry_count = entry_count_reg;
    assign last        = last_reg;

`ifndef SYNTH
    // fill count moves only together with a result beat
    a_count_with_beat: assert property (@(posedge clk) disable iff (!rst_n)
        (count_reg != $past(count_reg)) |-> done_reg)
        else $error("fill count changed without a result beat");

    // fill count steps by at most one per command
    a_count_step: assert property (@(posedge clk) disable iff (!rst_n)
        (count_reg == $past(count_reg)) || (count_reg == $past(count_reg) + 7'd1) ||
        (count_reg == $past(count_reg) - 7'd1))
        else $error("fill count jumped");

    // writes never land beyond the slot just past the list
    a_write_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        ram_we |-> (CNT_W'(ram_waddr) <= count_reg))
        else $error("store write outside the list");

    // a search hit is a single ok beat
    a_hit_beat: assert property (@(posedge clk) disable iff (!rst_n)
        (done_reg && found_reg) |-> ((status_reg == ST_OK) && last_reg))
        else $error("search hit beat malformed");

    // no read left in flight once idle
    a_idle_drained: assert property (@(posedge clk) disable iff (!rst_n)
        !busy |-> (!lag_valid_reg && !issue_reg))
        else $error("scan still in flight while idle");
`endif

endmodule

@@ design/ple_ram.sv @@
module ple_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // one write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

@@ test/tb_positional_list_engine_core.sv @@
module tb_positional_list_engine_core;
    import ple_pkg::*;

    // command codes past the defined set act as no-ops
    localparam logic [CMD_W-1:0] CMD_SPARE_LO = 4'd10;
    localparam logic [CMD_W-1:0] CMD_SPARE_HI = 4'd15;
    localparam logic [CNT_W-1:0] INDEX_MAX    = 7'd127;
    localparam int               QUIET_LIMIT  = 1000;
    localparam int               TAIL_CYCLES  = 150;

    typedef struct {
        status_t             status;
        logic                found;
        logic [FIDX_W-1:0]   found_index;
        logic [DATA_W-1:0]   out_value;
        logic [CNT_W-1:0]    entry_count;
        logic                last;
    } list_beat_t;

    typedef enum {GROW_MODE, SHRINK_MODE, MIXED_MODE} traffic_mode_t;

    // shadow list plus the queue of beats still owed by the block
    class list_scoreboard;
        logic [DATA_W-1:0] entries[$];
        list_beat_t        owed_beats[$];
        int                error_count;

        function int fill();
            return entries.size();
        endfunction

        function void owe_beat(status_t st, logic hit, int fidx, logic [DATA_W-1:0] v,
                               logic lst);
            list_beat_t b;
            b.status      = st;
            b.found       = hit;
            b.found_index = fidx[FIDX_W-1:0];
            b.out_value   = v;
            b.entry_count = CNT_W'(entries.size());
            b.last        = lst;
            owed_beats.push_back(b);
        endfunction

        task flag_mismatch(string what);
            error_count++;
            $display("mismatch: %s", what);
        endtask

        // apply one accepted command to the shadow list and queue its beats
        function void note_command(logic [CMD_W-1:0] c, logic [DATA_W-1:0] v,
                                   logic [CNT_W-1:0] idx);
            int               n;
            int               pos;
            status_t          st;
            logic [DATA_W-1:0] tmp;
            n  = entries.size();
            st = ST_OK;
            case (c)
                CMD_ADD_FRONT, CMD_ADD_BACK, CMD_INSERT_AT:
                begin
                    pos = (c == CMD_ADD_FRONT) ? 0 : (c == CMD_ADD_BACK) ? n : int'(idx);
                    if (n >= CAPACITY)
                        st = ST_FULL;
                    else if (pos > n)
                        st = ST_INVALID;
                    else
                        entries.insert(pos, v);
                end
                CMD_REMOVE_FRONT, CMD_REMOVE_BACK, CMD_REMOVE_AT:
                begin
                    pos = (c == CMD_REMOVE_FRONT) ? 0 :
                          (c == CMD_REMOVE_BACK) ? ((n == 0) ? 0 : n - 1) : int'(idx);
                    if (n == 0)
                        st = ST_EMPTY;
                    else if (pos >= n)
                        st = ST_INVALID;
                    else
                        entries.delete(pos);
                end
                CMD_SEARCH:
                begin
                    for (int j = 0; j < n; j++)
                    begin
                        if (entries[j] == v)
                        begin
                            owe_beat(ST_OK, 1'b1, j, '0, 1'b1);
                            return;
                        end
                    end
                    st = ST_NOT_FOUND;
                end
                CMD_UPDATE:
                begin
                    if (int'(idx) >= n)
                        st = ST_INVALID;
                    else
                        entries[idx] = v;
                end
                CMD_REVERSE:
                begin
                    for (int j = 0; j < n / 2; j++)
                    begin
                        tmp              = entries[j];
                        entries[j]       = entries[n - 1 - j];
                        entries[n - 1 - j] = tmp;
                    end
                end
                CMD_DUMP:
                begin
                    if (n == 0)
                        st = ST_EMPTY;
                    else
                    begin
                        for (int j = 0; j < n; j++)
                            owe_beat(ST_OK, 1'b0, 0, entries[j], j == n - 1);
                        return;
                    end
                end
                default: ;
            endcase
            owe_beat(st, 1'b0, 0, '0, 1'b1);
        endfunction

        task check_field(string name, logic [DATA_W-1:0] want, logic [DATA_W-1:0] got);
            if (got !== want)
                flag_mismatch($sformatf("%s expected %h got %h", name, want, got));
        endtask

        // compare one result beat against the oldest owed beat
        task check_result(logic [ST_W-1:0] st, logic hit, logic [FIDX_W-1:0] fidx,
                          logic [DATA_W-1:0] v, logic [CNT_W-1:0] cnt, logic lst);
            list_beat_t want;
            if (owed_beats.size() == 0)
            begin
                flag_mismatch($sformatf("result beat with none owed, status %0d", st));
                return;
            end
            want = owed_beats.pop_front();
            check_field("status", 32'(want.status), 32'(st));
            check_field("found", 32'(want.found), 32'(hit));
            check_field("found_index", 32'(want.found_index), 32'(fidx));
            check_field("out_value", want.out_value, v);
            check_field("entry_count", 32'(want.entry_count), 32'(cnt));
            check_field("last", 32'(want.last), 32'(lst));
        endtask
    endclass

    logic                     clk;
    logic                     rst_n;
    logic                     start;
    logic                     busy;
    logic [CMD_W-1:0]         cmd;
    logic signed [DATA_W-1:0] entry_value;
    logic [CNT_W-1:0]         index;
    logic                     done;
    logic [ST_W-1:0]          status;
    logic                     found;
    logic [FIDX_W-1:0]        found_index;
    logic signed [DATA_W-1:0] out_value;
    logic [CNT_W-1:0]         entry_count;
    logic                     last;

    list_scoreboard sb;
    int             sender_idle_pct;
    int             quiet_cycles;
    int             full_attempts;
    traffic_mode_t  mode;

    positional_list_engine_core u_top (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (start),
        .busy        (busy),
        .cmd         (cmd),
        .entry_value (entry_value),
        .index       (index),
        .done        (done),
        .status      (status),
        .found       (found),
        .found_index (found_index),
        .out_value   (out_value),
        .entry_count (entry_count),
        .last        (last)
    );

    // clock
    initial clk = 1'b0;
    always #6 clk = ~clk;

    // result monitor
    always @(posedge clk)
    begin
        if (rst_n && done)
            sb.check_result(status, found, found_index, out_value, entry_count, last);
    end

    // watchdog on cycles with no beat moving either way
    always @(posedge clk)
    begin
        if (!rst_n || (start && !busy) || done)
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= QUIET_LIMIT)
        begin
            $display("TB_ERROR");
            $finish;
        end
    end

    // present one command beat and wait until it is taken
    task automatic send_command(logic [CMD_W-1:0] c, logic [DATA_W-1:0] v,
                                logic [CNT_W-1:0] idx);
        int gap;
        if (sender_idle_pct > 0 && $urandom_range(99) < sender_idle_pct)
        begin
            gap = $urandom_range(1, 6);
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        start       <= 1'b1;
        cmd         <= c;
        entry_value <= v;
        index       <= idx;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        sb.note_command(c, v, idx);
    endtask

    function automatic logic [DATA_W-1:0] pick_value();
        int r;
        r = $urandom_range(99);
        if (r < 50)
            return $urandom;
        else if (r < 80)
            return DATA_W'($urandom_range(0, 7));
        else
        begin
            case ($urandom_range(3))
                0: return 32'h8000_0000;
                1: return 32'h7fff_ffff;
                2: return 32'hffff_ffff;
                default: return 32'h0;
            endcase
        end
    endfunction

    function automatic logic [CNT_W-1:0] pick_index(int n);
        int r;
        r = $urandom_range(99);
        if (r < 75)
            return CNT_W'($urandom_range(0, n));
        else if (r < 88)
            return CNT_W'(n);
        else
            return CNT_W'($urandom_range(0, INDEX_MAX));
    endfunction

    // random traffic biased so the list swings between empty and full
    task automatic run_random(int items, int idle_pct);
        int               n;
        int               r;
        logic [CMD_W-1:0] c;
        logic [DATA_W-1:0] v;
        sender_idle_pct = idle_pct;
        for (int k = 0; k < items; k++)
        begin
            n = sb.fill();
            if (n == CAPACITY && mode == GROW_MODE)
            begin
                full_attempts++;
                if (full_attempts > 4)
                    mode = SHRINK_MODE;
            end
            else if (n == 0 && mode == SHRINK_MODE)
                mode = GROW_MODE;
            else if ($urandom_range(39) == 0)
                mode = traffic_mode_t'($urandom_range(0, 2));
            if (mode == GROW_MODE && n < CAPACITY)
                full_attempts = 0;
            r = $urandom_range(99);
            if ((mode == GROW_MODE && r < 82) || (mode == MIXED_MODE && r < 35))
                c = cmd_t'($urandom_range(CMD_ADD_FRONT, CMD_INSERT_AT));
            else if ((mode == SHRINK_MODE && r < 65) || (mode == MIXED_MODE && r < 65))
                c = cmd_t'($urandom_range(CMD_REMOVE_FRONT, CMD_REMOVE_AT));
            else
            begin
                r = $urandom_range(99);
                if (r < 35)
                    c = CMD_SEARCH;
                else if (r < 60)
                    c = CMD_UPDATE;
                else if (r < 75)
                    c = CMD_REVERSE;
                else if (r < 90)
                    c = CMD_DUMP;
                else
                    c = CMD_W'($urandom_range(CMD_SPARE_LO, CMD_SPARE_HI));
            end
            v = pick_value();
            // searches mostly look for something that is stored
            if (c == CMD_SEARCH && n > 0 && $urandom_range(99) < 60)
                v = sb.entries[$urandom_range(0, n - 1)];
            send_command(c, v, pick_index(n));
        end
    endtask

    // stimulus
    initial
    begin
        sb              = new();
        sender_idle_pct = 0;
        full_attempts   = 0;
        mode            = GROW_MODE;
        rst_n           <= 1'b0;
        start           <= 1'b0;
        cmd             <= CMD_ADD_FRONT;
        entry_value     <= '0;
        index           <= '0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        // empty list corner cases
        send_command(CMD_DUMP, 32'h0, 7'd0);
        send_command(CMD_REMOVE_FRONT, 32'h0, 7'd0);
        send_command(CMD_REMOVE_BACK, 32'h0, 7'd0);
        send_command(CMD_REMOVE_AT, 32'h0, 7'd0);
        send_command(CMD_SEARCH, 32'h0, 7'd0);
        send_command(CMD_REVERSE, 32'h0, 7'd0);
        send_command(CMD_UPDATE, 32'h1, 7'd0);
        send_command(CMD_INSERT_AT, 32'h1, 7'd1);
        // build a short list with extreme values
        send_command(CMD_INSERT_AT, 32'h8000_0000, 7'd0);
        send_command(CMD_ADD_BACK, 32'h7fff_ffff, 7'd0);
        send_command(CMD_ADD_FRONT, 32'hffff_ffff, 7'd0);
        send_command(CMD_INSERT_AT, 32'h7fff_ffff, 7'd3);
        send_command(CMD_SEARCH, 32'h7fff_ffff, 7'd0);
        send_command(CMD_UPDATE, 32'h0, 7'd0);
        send_command(CMD_UPDATE, 32'h0, 7'd4);
        send_command(CMD_REMOVE_AT, 32'h0, 7'd1);
        send_command(CMD_REVERSE, 32'h0, 7'd0);
        send_command(CMD_DUMP, 32'h0, 7'd0);
        send_command(CMD_INSERT_AT, 32'h5, INDEX_MAX);
        send_command(CMD_REMOVE_AT, 32'h0, INDEX_MAX);
        send_command(CMD_REMOVE_FRONT, 32'h0, 7'd0);
        send_command(CMD_REMOVE_BACK, 32'h0, 7'd0);
        send_command(CMD_SEARCH, 32'h1234_5678, 7'd0);
        send_command(CMD_SPARE_LO, 32'hffff_ffff, INDEX_MAX);
        send_command(CMD_SPARE_HI, 32'h0, 7'd0);

        // random traffic under three sender idle rates
        run_random(87, 8);
        run_random(87, 72);
        run_random(87, 0);

        start <= 1'b0;
        while (sb.owed_beats.size() != 0)
            @(posedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);
        if (sb.owed_beats.size() != 0)
            sb.flag_mismatch("result beats still owed at end of run");
        if (sb.error_count == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule
